// ===== hdl/npdown_pkg.sv =====
// shared types, codes and constants of the power-of-two texture downscaler
// no dependencies
package npdown_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PIXEL_W = 32;
   localparam int SLOT_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RESET_IN_WIDTH = 13'd256;
   localparam logic [CSR_DATA_W-1:0] RESET_IN_HEIGHT = 13'd256;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PALETTE = 1'b1;

   localparam logic FMT_RGBA = 1'b0;
   localparam logic FMT_INDEXED = 1'b1;

   localparam logic [PIXEL_W-1:0] KEEP_MASK = 32'hff00ff00;
   localparam logic [PIXEL_W-1:0] LOW_BYTE_MASK = 32'h000000ff;
   localparam logic [PIXEL_W-1:0] HIGH_BYTE_MASK = 32'h00ff0000;

   typedef struct packed {
      logic fire;
      logic last_in_row;
      logic last_in_image;
      logic use_palette;
      logic palette_zero;
   } sample_type;

   function automatic logic [PIXEL_W-1:0] swap_rb(input logic [PIXEL_W-1:0] v);
      return (v & KEEP_MASK) | ((v & LOW_BYTE_MASK) << 16) | ((v & HIGH_BYTE_MASK) >> 16);
   endfunction

endpackage

// ===== hdl/npdown_palette.sv =====
// palette memory: one write and one registered read per cycle
// depends on npdown_pkg
module npdown_palette #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int PAL_AW = 8
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [PAL_AW-1:0]            wr_addr,
   input  logic [npdown_pkg::PIXEL_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [PAL_AW-1:0]            rd_addr,
   output logic [npdown_pkg::PIXEL_W-1:0] rd_data
);
   import npdown_pkg::*;

   logic [PIXEL_W-1:0] pal_ff [PALETTE_ENTRIES];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pal_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/npdown_sampler.sv =====
// configuration registers, output geometry and the raster sampling counters
// depends on npdown_pkg
module npdown_sampler #(
   parameter int MAX_IN_DIM = 4096,
   parameter int MAX_OUT_DIM = 256,
   parameter int PALETTE_ENTRIES = 256,
   parameter int PAL_AW = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [npdown_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [npdown_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            accept,
   input  logic                            kind,
   input  logic [npdown_pkg::PIXEL_W-1:0]    value,
   input  logic [npdown_pkg::SLOT_W-1:0]     palette_slot,
   output npdown_pkg::sample_type          sample,
   output logic                            pal_wr_en,
   output logic [PAL_AW-1:0]               pal_wr_addr,
   output logic                            pal_rd_en,
   output logic [PAL_AW-1:0]               pal_rd_addr
);
   import npdown_pkg::*;

   localparam int DIM_W = $clog2(MAX_IN_DIM + 1);
   localparam int IDX_W = $clog2(MAX_IN_DIM);
   localparam int ACC_W = DIM_W + FRAC_BITS;
   localparam int OCOL_W = $clog2(MAX_OUT_DIM + 1);
   localparam int OUT_LOG = $clog2(MAX_OUT_DIM);
   localparam int LOG_W = $clog2(DIM_W);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] d);
      if (d == '0) begin
         return DIM_W'(1);
      end
      if (32'(d) > MAX_IN_DIM) begin
         return DIM_W'(MAX_IN_DIM);
      end
      return DIM_W'(d);
   endfunction

   // highest set bit, capped at log2 of the largest output size
   function automatic logic [LOG_W-1:0] dim_log(input logic [DIM_W-1:0] v);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 0; i < DIM_W; i++) begin
         if (v[i]) begin
            k = (i > OUT_LOG) ? LOG_W'(OUT_LOG) : LOG_W'(i);
         end
      end
      return k;
   endfunction

   // configuration
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic                  format_ff, format_in;

   // geometry derived from configuration
   logic [DIM_W-1:0]  iw_ff, iw_in, ih_ff, ih_in;
   logic [OCOL_W-1:0] ow_m1_ff, ow_m1_in, oh_m1_ff, oh_m1_in;
   logic [ACC_W-1:0]  stx_ff, stx_in, sty_ff, sty_in;
   logic [LOG_W-1:0]  kx, ky;

   // raster state
   logic [IDX_W-1:0]  in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [ACC_W-1:0]  col_acc_ff, col_acc_in, row_acc_ff, row_acc_in;
   logic [OCOL_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;

   logic pixel, row_hit, col_hit, col_end, row_end, width_ok, idx_ok;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      format_in = format_ff;
      if (reset) begin
         width_in = RESET_IN_WIDTH;
         height_in = RESET_IN_HEIGHT;
         format_in = FMT_RGBA;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_IN_WIDTH: width_in = csr_wdata;
            REG_IN_HEIGHT: height_in = csr_wdata;
            REG_PIXEL_FORMAT: format_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      iw_in = clamp_dim(width_in);
      ih_in = clamp_dim(height_in);
      kx = dim_log(iw_in);
      ky = dim_log(ih_in);
      ow_m1_in = OCOL_W'((32'd1 << kx) - 32'd1);
      oh_m1_in = OCOL_W'((32'd1 << ky) - 32'd1);
      stx_in = {iw_in, {FRAC_BITS{1'b0}}} >> kx;
      sty_in = {ih_in, {FRAC_BITS{1'b0}}} >> ky;
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      height_ff <= height_in;
      format_ff <= format_in;
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      ow_m1_ff <= ow_m1_in;
      oh_m1_ff <= oh_m1_in;
      stx_ff <= stx_in;
      sty_ff <= sty_in;
   end

   always_comb begin
      pixel = accept && (kind == KIND_PIXEL);
      width_ok = (iw_ff[1:0] == 2'b00);
      row_hit = (out_row_ff <= oh_m1_ff)
                && (row_acc_ff[ACC_W-1:FRAC_BITS] == DIM_W'(in_row_ff));
      col_hit = row_hit && (out_col_ff <= ow_m1_ff)
                && (col_acc_ff[ACC_W-1:FRAC_BITS] == DIM_W'(in_col_ff));
      col_end = DIM_W'(in_col_ff) >= (iw_ff - DIM_W'(1));
      row_end = DIM_W'(in_row_ff) >= (ih_ff - DIM_W'(1));
      idx_ok = 32'(value[SLOT_W-1:0]) < PALETTE_ENTRIES;

      sample.fire = pixel && col_hit && width_ok;
      sample.last_in_row = (out_col_ff == ow_m1_ff);
      sample.last_in_image = (out_col_ff == ow_m1_ff) && (out_row_ff == oh_m1_ff);
      sample.use_palette = (format_ff == FMT_INDEXED);
      sample.palette_zero = !idx_ok;

      pal_rd_en = sample.fire && (format_ff == FMT_INDEXED) && idx_ok;
      pal_rd_addr = value[PAL_AW-1:0];
      pal_wr_en = accept && (kind == KIND_PALETTE)
                  && (32'(palette_slot) < PALETTE_ENTRIES);
      pal_wr_addr = palette_slot[PAL_AW-1:0];

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      col_acc_in = col_acc_ff;
      row_acc_in = row_acc_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (pixel) begin
         if (col_hit) begin
            out_col_in = out_col_ff + OCOL_W'(1);
            col_acc_in = col_acc_ff + stx_ff;
         end
         if (col_end) begin
            in_col_in = '0;
            col_acc_in = '0;
            out_col_in = '0;
            if (row_hit) begin
               out_row_in = out_row_ff + OCOL_W'(1);
               row_acc_in = row_acc_ff + sty_ff;
            end
            if (row_end) begin
               in_row_in = '0;
               row_acc_in = '0;
               out_row_in = '0;
            end else begin
               in_row_in = in_row_ff + IDX_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         col_acc_ff <= '0;
         row_acc_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         col_acc_ff <= col_acc_in;
         row_acc_ff <= row_acc_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ===== hdl/nearest_pow2_texture_downscaler.sv =====
// top level of the power-of-two nearest-sample texture downscaler
// depends on npdown_pkg, npdown_sampler, npdown_palette
//
// usage:
//  - req_* carries one request per cycle while req_ready is high: an image pixel (req_kind 0) in raster
//    order, or a palette entry write (req_kind 1) to req_palette_slot
//  - rsp_* returns each sampled pixel with red and blue swapped, flagged at the
//    end of an output row and of the output image; unsampled pixels, palette
//    writes and images whose width is not a multiple of 4 return nothing
//  - csr_* writes in_width, in_height and pixel_format; write only while idle
//  - a sampled pixel is registered in s1 and then in the rsp register
//  - one request per cycle while req_ready is high; the sampling decision and the palette
//    read (registered synchronous memory) each take one stage
//  - reset clears the raster counters and loads 256 x 256 rgba; palette
//    contents stay undefined until written
//  - when rsp_ready is low the two result stages fill, then req_ready drops
module nearest_pow2_texture_downscaler #(
   parameter int MAX_IN_DIM = 4096,
   parameter int MAX_OUT_DIM = 256,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [npdown_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [npdown_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [npdown_pkg::PIXEL_W-1:0]    req_value,
   input  logic [npdown_pkg::SLOT_W-1:0]     req_palette_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [npdown_pkg::PIXEL_W-1:0]    rsp_pixel_bgr,
   output logic                            rsp_last_in_row,
   output logic                            rsp_last_in_image
);
   import npdown_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   logic               accept;
   sample_type         sample;
   logic               pal_wr_en, pal_rd_en;
   logic [PAL_AW-1:0]  pal_wr_addr, pal_rd_addr;
   logic [PIXEL_W-1:0] pal_rd_data;

   logic               s1_valid_ff, s1_valid_in;
   sample_type         s1_sample_ff;
   logic [PIXEL_W-1:0] s1_value_ff;
   logic               s1_advance;
   logic [PIXEL_W-1:0] s1_pixel;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;
   logic               rsp_last_row_ff, rsp_last_image_ff;

   npdown_sampler #(
      .MAX_IN_DIM(MAX_IN_DIM),
      .MAX_OUT_DIM(MAX_OUT_DIM),
      .PALETTE_ENTRIES(PALETTE_ENTRIES),
      .PAL_AW(PAL_AW)
   ) u_sampler (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .kind(req_kind),
      .value(req_value),
      .palette_slot(req_palette_slot),
      .sample(sample),
      .pal_wr_en(pal_wr_en),
      .pal_wr_addr(pal_wr_addr),
      .pal_rd_en(pal_rd_en),
      .pal_rd_addr(pal_rd_addr)
   );

   npdown_palette #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES),
      .PAL_AW(PAL_AW)
   ) u_palette (
      .clock(clock),
      .wr_en(pal_wr_en),
      .wr_addr(pal_wr_addr),
      .wr_data(req_value),
      .rd_en(pal_rd_en),
      .rd_addr(pal_rd_addr),
      .rd_data(pal_rd_data)
   );

   always_comb begin
      s1_advance = !rsp_valid_ff || rsp_ready;
      req_ready = !s1_valid_ff || s1_advance;
      accept = req_valid && req_ready;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = sample.fire;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
      if (!s1_sample_ff.use_palette) begin
         s1_pixel = s1_value_ff;
      end else if (s1_sample_ff.palette_zero) begin
         s1_pixel = '0;
      end else begin
         s1_pixel = pal_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_value_ff <= req_value;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_pixel_ff <= swap_rb(s1_pixel);
         rsp_last_row_ff <= s1_sample_ff.last_in_row;
         rsp_last_image_ff <= s1_sample_ff.last_in_image;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_bgr = rsp_pixel_ff;
   assign rsp_last_in_row = rsp_last_row_ff;
   assign rsp_last_in_image = rsp_last_image_ff;

endmodule
